>>> sv/sqc_pkg.sv
// Types, register indexes and scaling functions of the stick to quadrature converter.
// Has no dependencies. The configuration block and the core both use it.
package sqc_pkg;

  localparam int unsigned RawW  = 10;
  localparam int unsigned PosW  = 8;
  localparam int unsigned PendW = 10;
  localparam logic signed [PendW-1:0] PendMax = 10'sd511;
  localparam logic signed [PendW-1:0] PendMin = -10'sd511;
  localparam logic [7:0] XWheelInit = 8'b11001100;
  localparam logic [7:0] YWheelInit = 8'b00110011;
  localparam logic [9:0] NeutralInit = 10'd512;
  localparam logic [7:0] ReachInit = 8'd105;

  typedef enum logic [3:0] {
    REG_QUAD_NE   = 4'd0,
    REG_QUAD_SE   = 4'd1,
    REG_QUAD_SW   = 4'd2,
    REG_QUAD_NW   = 4'd3,
    REG_CARDINAL  = 4'd4,
    REG_NEUTRAL_X = 4'd5,
    REG_NEUTRAL_Y = 4'd6,
    REG_REACH     = 4'd7
  } reg_idx_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_e;

  // Quadrant register, lowest field last.
  typedef struct packed {
    logic [7:0]      factor_y;
    logic [7:0]      factor_x;
    logic [RawW-1:0] limit_y;
    logic [RawW-1:0] limit_x;
  } quad_t;

  typedef struct packed {
    logic [7:0] west;
    logic [7:0] south;
    logic [7:0] east;
    logic [7:0] north;
  } card_t;

  typedef struct packed {
    quad_t           ne;
    quad_t           se;
    quad_t           sw;
    quad_t           nw;
    card_t           card;
    logic [RawW-1:0] neutral_x;
    logic [RawW-1:0] neutral_y;
    logic [PosW-1:0] reach;
    logic [PosW-1:0] center_x;   // scaled neutral position
    logic [PosW-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] sx;
    logic [PosW-1:0] sy;
  } pair_t;

  typedef struct packed {
    logic [1:0]      x_phase;
    logic [1:0]      y_phase;
    logic [PosW-1:0] scaled_x;
    logic [PosW-1:0] scaled_y;
    logic            busy;
  } result_t;

  function automatic logic [PosW-1:0] scale_axis(logic [RawW-1:0] raw, logic [7:0] f);
    logic [RawW+7:0] p;
    p = (RawW+8)'(raw) * (RawW+8)'(f);
    return p[15:8];
  endfunction

  function automatic pair_t scale_pair(logic [RawW-1:0] rx, logic [RawW-1:0] ry,
                                       logic [RawW-1:0] nx, logic [RawW-1:0] ny,
                                       quad_t ne, quad_t se, quad_t sw, quad_t nw,
                                       card_t card);
    logic  xp;
    logic  yp;
    quad_t q;
    logic [7:0] fx;
    logic [7:0] fy;
    pair_t r;
    xp = rx > nx;
    yp = ry > ny;
    if (xp && yp) q = ne;
    else if (xp) q = se;
    else if (!yp) q = sw;
    else q = nw;
    fx = q.factor_x;
    fy = q.factor_y;
    if (xp) begin
      if (rx > q.limit_x) fx = card.east;
    end else begin
      if (rx < q.limit_x) fx = card.west;
    end
    if (yp) begin
      if (ry > q.limit_y) fy = card.north;
    end else begin
      if (ry < q.limit_y) fy = card.south;
    end
    r.sx = scale_axis(rx, fx);
    r.sy = scale_axis(ry, fy);
    return r;
  endfunction

endpackage

>>> sv/sqc_cfg.sv
// Configuration registers of the stick to quadrature converter, plus the
// registered scaled neutral position. Depends on sqc_pkg.
module sqc_cfg
  import sqc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [3:0] wr_addr_i,
  input  logic [35:0] wr_data_i,
  output cfg_t       cfg_o
);

  quad_t ne_q, se_q, sw_q, nw_q;
  card_t card_q;
  logic [RawW-1:0] neutral_x_q, neutral_y_q;
  logic [PosW-1:0] reach_q;
  logic [PosW-1:0] center_x_q, center_y_q;
  pair_t center_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q        <= '0;
      se_q        <= '0;
      sw_q        <= '0;
      nw_q        <= '0;
      card_q      <= '0;
      neutral_x_q <= NeutralInit;
      neutral_y_q <= NeutralInit;
      reach_q     <= ReachInit;
    end else if (wr_en_i) begin
      case (reg_idx_e'(wr_addr_i))
        REG_QUAD_NE:   ne_q        <= quad_t'(wr_data_i);
        REG_QUAD_SE:   se_q        <= quad_t'(wr_data_i);
        REG_QUAD_SW:   sw_q        <= quad_t'(wr_data_i);
        REG_QUAD_NW:   nw_q        <= quad_t'(wr_data_i);
        REG_CARDINAL:  card_q      <= card_t'(wr_data_i[31:0]);
        REG_NEUTRAL_X: neutral_x_q <= wr_data_i[RawW-1:0];
        REG_NEUTRAL_Y: neutral_y_q <= wr_data_i[RawW-1:0];
        REG_REACH:     reach_q     <= wr_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // The neutral point always lands in the lower-left quadrant. Its scaled
  // position is registered from the registers, which happens before any item
  // accepted after a write reaches the core.
  assign center_d = scale_pair(neutral_x_q, neutral_y_q, neutral_x_q, neutral_y_q,
                               ne_q, se_q, sw_q, nw_q, card_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else begin
      center_x_q <= center_d.sx;
      center_y_q <= center_d.sy;
    end
  end

  assign cfg_o.ne        = ne_q;
  assign cfg_o.se        = se_q;
  assign cfg_o.sw        = sw_q;
  assign cfg_o.nw        = nw_q;
  assign cfg_o.card      = card_q;
  assign cfg_o.neutral_x = neutral_x_q;
  assign cfg_o.neutral_y = neutral_y_q;
  assign cfg_o.reach     = reach_q;
  assign cfg_o.center_x  = center_x_q;
  assign cfg_o.center_y  = center_y_q;

endmodule

>>> sv/sqc_core.sv
// Stick state and per-item update: scaling, clamp, pending steps and wheels.
// Depends on sqc_pkg.
module sqc_core
  import sqc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            en_i,
  input  logic            req_type_i,
  input  logic [RawW-1:0] raw_x_i,
  input  logic [RawW-1:0] raw_y_i,
  output result_t         res_o
);

  logic [7:0] x_wheel_q, x_wheel_d, y_wheel_q, y_wheel_d;
  logic [PosW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [PendW-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic started_q, started_d;
  pair_t raw_s;
  logic [PosW-1:0] px, py;

  function automatic logic [PosW-1:0] clamp_pos(logic [PosW-1:0] p, logic [PosW-1:0] n,
                                                logic [PosW-1:0] mr);
    logic [PosW-1:0] r;
    r = p;
    if (p > n && (p - n) > mr) r = n + mr;
    else if (p < n && (n - p) > mr) r = n - mr;
    return r;
  endfunction

  function automatic logic signed [PendW-1:0] sat_add(logic signed [PendW-1:0] a,
                                                      logic [PosW-1:0] p,
                                                      logic [PosW-1:0] o);
    logic signed [PendW+1:0] s;
    s = (PendW+2)'(a) + $signed({4'b0000, p}) - $signed({4'b0000, o});
    if (s > (PendW+2)'(PendMax)) s = (PendW+2)'(PendMax);
    if (s < (PendW+2)'(PendMin)) s = (PendW+2)'(PendMin);
    return s[PendW-1:0];
  endfunction

  assign raw_s = scale_pair(raw_x_i, raw_y_i, cfg_i.neutral_x, cfg_i.neutral_y,
                            cfg_i.ne, cfg_i.se, cfg_i.sw, cfg_i.nw, cfg_i.card);
  assign px = clamp_pos(raw_s.sx, cfg_i.center_x, cfg_i.reach);
  assign py = clamp_pos(raw_s.sy, cfg_i.center_y, cfg_i.reach);

  always_comb begin
    x_wheel_d = x_wheel_q;
    y_wheel_d = y_wheel_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    pend_x_d  = pend_x_q;
    pend_y_d  = pend_y_q;
    started_d = started_q;
    if (req_type_e'(req_type_i) == REQ_SAMPLE) begin
      // Before the first sample the change is measured from neutral.
      pend_x_d  = sat_add(pend_x_q, px, started_q ? prev_x_q : cfg_i.center_x);
      pend_y_d  = sat_add(pend_y_q, py, started_q ? prev_y_q : cfg_i.center_y);
      prev_x_d  = px;
      prev_y_d  = py;
      started_d = 1'b1;
    end else begin
      if (pend_x_q < 0) begin
        x_wheel_d = {x_wheel_q[6:0], x_wheel_q[7]};
        pend_x_d  = pend_x_q + 10'sd1;
      end else if (pend_x_q > 0) begin
        x_wheel_d = {x_wheel_q[0], x_wheel_q[7:1]};
        pend_x_d  = pend_x_q - 10'sd1;
      end
      if (pend_y_q > 0) begin
        y_wheel_d = {y_wheel_q[0], y_wheel_q[7:1]};
        pend_y_d  = pend_y_q - 10'sd1;
      end else if (pend_y_q < 0) begin
        y_wheel_d = {y_wheel_q[6:0], y_wheel_q[7]};
        pend_y_d  = pend_y_q + 10'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_wheel_q <= XWheelInit;
      y_wheel_q <= YWheelInit;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      pend_x_q  <= '0;
      pend_y_q  <= '0;
      started_q <= 1'b0;
    end else if (en_i) begin
      x_wheel_q <= x_wheel_d;
      y_wheel_q <= y_wheel_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      pend_x_q  <= pend_x_d;
      pend_y_q  <= pend_y_d;
      started_q <= started_d;
    end
  end

  assign res_o.x_phase  = x_wheel_d[1:0];
  assign res_o.y_phase  = y_wheel_d[7:6];
  assign res_o.scaled_x = prev_x_d;
  assign res_o.scaled_y = prev_y_d;
  assign res_o.busy     = (pend_x_d != '0) || (pend_y_d != '0);

endmodule

>>> sv/stick_to_quadrature_converter.sv
// Top level of the stick to quadrature converter: input register, core and
// result register. Depends on sqc_pkg, sqc_cfg and sqc_core.
//
//   channel   direction  handshake              contents
//   s_axis    in         tvalid/tready          sample or tick request
//   m_axis    out        tvalid/tready          phases, scaled position, busy
//   cfg       in         cfg_valid/cfg_ready    register index and data
//
// Each request is held in the input register and is processed into the
// result register; one request per cycle is sustained while m_axis is not
// stalled. The path from input register to result register holds two 10x8
// multiplies, clamp and saturating add. A stall on m_axis holds the result
// register and a full input register; cfg writes are always taken. Reset
// loads the register and wheel defaults and clears the other stick state.
module stick_to_quadrature_converter
  import sqc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_x[9:0], raw_y[19:10], zero[23:20]
  input  logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // x_phase[1:0], y_phase[3:2], scaled_x[11:4], scaled_y[19:12],
  // busy_res[20], zero[23:21]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [35:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res_d, res_q;
  logic    in_valid_q, out_valid_q;
  logic    req_type_q;
  logic [RawW-1:0] raw_x_q, raw_y_q;
  logic    advance;
  logic    fire;

  assign cfg_ready_o = 1'b1;

  sqc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The pipeline moves whenever the result register is free or being read.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_type_q <= s_axis_tuser[0];
      raw_x_q    <= s_axis_tdata[9:0];
      raw_y_q    <= s_axis_tdata[19:10];
    end
  end

  sqc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .en_i       (fire),
    .req_type_i (req_type_q),
    .raw_x_i    (raw_x_q),
    .raw_y_i    (raw_y_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.busy, res_q.scaled_y, res_q.scaled_x,
                          res_q.y_phase, res_q.x_phase};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of stick_to_quadrature_converter: directed and random sample
// and tick requests, checked against a behavioral model of scaling, clamp and wheels.
// Depends on sqc_pkg and the converter RTL.
module testbench;
  import sqc_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RegCount     = 8;
  localparam int MaxPrinted   = 50;
  localparam int SettleCycles = 4;
  localparam int PhaseCount   = 8;

  typedef enum int {
    CFG_RANDOM,
    CFG_LOW_EDGE,
    CFG_HIGH_EDGE,
    CFG_LIMIT_EDGE
  } cfg_style_e;

  typedef struct {
    req_type_e  kind;
    logic [9:0] rx;
    logic [9:0] ry;
  } stick_req_t;

  typedef struct {
    logic [3:0]  addr;
    logic [35:0] data;
  } reg_write_t;

  typedef struct {
    logic [1:0] x_phase;
    logic [1:0] y_phase;
    logic [7:0] scaled_x;
    logic [7:0] scaled_y;
    logic       busy;
  } readout_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_addr_i    = '0;
  logic [35:0] cfg_data_i    = '0;

  // Model copy of the registers and the stick state.
  quad_t      quad_m [4] = '{default: '0};
  card_t      card_m     = '0;
  logic [9:0] nx_m       = NeutralInit;
  logic [9:0] ny_m       = NeutralInit;
  logic [7:0] mr_m       = ReachInit;
  logic [7:0] x_wheel    = XWheelInit;
  logic [7:0] y_wheel    = YWheelInit;
  logic [7:0] last_x     = '0;
  logic [7:0] last_y     = '0;
  int         pend_x     = 0;
  int         pend_y     = 0;
  bit         started    = 1'b0;

  stick_req_t req_q [$];
  reg_write_t reg_q [$];
  readout_t   readout_q [$];
  stick_req_t cur_req;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;

  stick_to_quadrature_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] scale_raw(logic [9:0] raw, logic [7:0] factor);
    return 8'((raw * 18'(factor)) >> 8);
  endfunction

  // Returns {scaled_y, scaled_x} before the clamp.
  function automatic logic [15:0] stick_position(logic [9:0] rx, logic [9:0] ry);
    logic       xp;
    logic       yp;
    quad_t      q;
    logic [7:0] fx;
    logic [7:0] fy;
    xp = rx > nx_m;
    yp = ry > ny_m;
    q  = quad_m[xp ? (yp ? REG_QUAD_NE : REG_QUAD_SE) : (yp ? REG_QUAD_NW : REG_QUAD_SW)];
    fx = q.factor_x;
    fy = q.factor_y;
    if (xp ? (rx > q.limit_x) : (rx < q.limit_x)) fx = xp ? card_m.east : card_m.west;
    if (yp ? (ry > q.limit_y) : (ry < q.limit_y)) fy = yp ? card_m.north : card_m.south;
    return {scale_raw(ry, fy), scale_raw(rx, fx)};
  endfunction

  // The bounds wrap at 8 bits, so a bound may land on the far side of the neutral.
  function automatic logic [7:0] clamp_to_reach(logic [7:0] p, logic [7:0] n);
    if (p > n && 8'(p - n) > mr_m) return 8'(n + mr_m);
    if (p < n && 8'(n - p) > mr_m) return 8'(n - mr_m);
    return p;
  endfunction

  function automatic int add_capped(int a, int b);
    int s;
    s = a + b;
    if (s > int'(PendMax)) s = int'(PendMax);
    if (s < int'(PendMin)) s = int'(PendMin);
    return s;
  endfunction

  task automatic step_converter(input stick_req_t q, output readout_t r);
    logic [15:0] center;
    logic [15:0] pos;
    logic [7:0]  px;
    logic [7:0]  py;
    if (q.kind == REQ_SAMPLE) begin
      center = stick_position(nx_m, ny_m);
      pos    = stick_position(q.rx, q.ry);
      px     = clamp_to_reach(pos[7:0], center[7:0]);
      py     = clamp_to_reach(pos[15:8], center[15:8]);
      pend_x = add_capped(pend_x, int'(px) - int'(started ? last_x : center[7:0]));
      pend_y = add_capped(pend_y, int'(py) - int'(started ? last_y : center[15:8]));
      last_x  = px;
      last_y  = py;
      started = 1'b1;
    end else begin
      if (pend_x < 0) begin
        x_wheel = {x_wheel[6:0], x_wheel[7]};
        pend_x++;
      end else if (pend_x > 0) begin
        x_wheel = {x_wheel[0], x_wheel[7:1]};
        pend_x--;
      end
      if (pend_y > 0) begin
        y_wheel = {y_wheel[0], y_wheel[7:1]};
        pend_y--;
      end else if (pend_y < 0) begin
        y_wheel = {y_wheel[6:0], y_wheel[7]};
        pend_y++;
      end
    end
    r.x_phase  = x_wheel[1:0];
    r.y_phase  = y_wheel[7:6];
    r.scaled_x = last_x;
    r.scaled_y = last_y;
    r.busy     = (pend_x != 0) || (pend_y != 0);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MaxPrinted) $display("%0t: readout mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Register writes and stick requests are both driven from here; the model is
  // updated at the edge where each request is taken.
  always @(posedge clk_i) begin : request_driver
    readout_t r;
    reg_write_t w;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          REG_QUAD_NE, REG_QUAD_SE, REG_QUAD_SW, REG_QUAD_NW: quad_m[cfg_addr_i[1:0]] = cfg_data_i;
          REG_CARDINAL:  card_m = cfg_data_i[31:0];
          REG_NEUTRAL_X: nx_m   = cfg_data_i[9:0];
          REG_NEUTRAL_Y: ny_m   = cfg_data_i[9:0];
          REG_REACH:     mr_m   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_q.size() != 0) begin
          w = reg_q.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_addr_i  <= w.addr;
          cfg_data_i  <= w.data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        step_converter(cur_req, r);
        readout_q.push_back(r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, cur_req.ry, cur_req.rx};
          s_axis_tuser  <= cur_req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : readout_monitor
    readout_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (readout_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = readout_q.pop_front();
        check_field("x_phase", m_axis_tdata[1:0], want.x_phase);
        check_field("y_phase", m_axis_tdata[3:2], want.y_phase);
        check_field("scaled_x", m_axis_tdata[11:4], want.scaled_x);
        check_field("scaled_y", m_axis_tdata[19:12], want.scaled_y);
        check_field("busy", m_axis_tdata[20], want.busy);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : watchdog
    if (cycle_cnt >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  function automatic logic [35:0] rand36();
    return {4'($urandom_range(15)), 32'($urandom)};
  endfunction

  // Raw readings lean toward the neutral and the rails, where the quadrant
  // selection and the clamp change behavior.
  function automatic logic [9:0] pick_raw(logic [9:0] neutral);
    int v;
    case ($urandom_range(7))
      0, 1, 2: v = int'($urandom_range(1023));
      3, 4:    v = int'(neutral) + int'($urandom_range(60)) - 30;
      5:       v = 0;
      6:       v = 1023;
      default: v = int'(neutral) + int'($urandom_range(2)) - 1;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic queue_reg(input logic [3:0] addr, input logic [35:0] data);
    reg_write_t w;
    w.addr = addr;
    w.data = data;
    reg_q.push_back(w);
  endtask

  task automatic queue_req(input req_type_e kind, input logic [9:0] rx, input logic [9:0] ry);
    stick_req_t q;
    q.kind = kind;
    q.rx   = rx;
    q.ry   = ry;
    req_q.push_back(q);
  endtask

  task automatic wait_cfg_done();
    do @(posedge clk_i); while (reg_q.size() != 0 || cfg_valid_i);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (req_q.size() != 0 || s_axis_tvalid || readout_q.size() != 0);
  endtask

  task automatic program_regs(input cfg_style_e style);
    logic [35:0] quad [4];
    logic [31:0] card;
    logic [9:0]  nx;
    logic [9:0]  ny;
    logic [7:0]  mr;
    case (style)
      CFG_LOW_EDGE: begin
        foreach (quad[i]) quad[i] = '1;
        card = '1;
        nx   = '0;
        ny   = '0;
        mr   = '0;
      end
      CFG_HIGH_EDGE: begin
        foreach (quad[i]) begin
          quad[i] = {8'($urandom), 8'($urandom), (i % 2) ? 10'd0 : 10'd1023,
                     (i % 2) ? 10'd1023 : 10'd0};
        end
        card = '0;
        nx   = '1;
        ny   = '1;
        mr   = '1;
      end
      CFG_LIMIT_EDGE: begin
        nx = 10'($urandom);
        ny = 10'($urandom);
        foreach (quad[i]) quad[i] = {8'($urandom), 8'($urandom), ny, nx};
        card = $urandom;
        mr   = 8'($urandom);
      end
      default: begin
        foreach (quad[i]) quad[i] = rand36();
        card = $urandom;
        nx   = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(624, 400));
        ny   = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(624, 400));
        mr   = 8'($urandom);
      end
    endcase
    queue_reg(4'(RegCount + $urandom_range(7)), rand36());
    foreach (quad[i]) queue_reg(4'(REG_QUAD_NE) + 4'(i), quad[i]);
    queue_reg(REG_CARDINAL, 36'(card));
    queue_reg(REG_NEUTRAL_X, 36'(nx));
    queue_reg(REG_NEUTRAL_Y, 36'(ny));
    queue_reg(REG_REACH, 36'(mr));
    wait_cfg_done();
  endtask

  // Each sample is followed by a run of ticks; now and then the run is long
  // enough to walk the pending steps back to zero.
  task automatic gen_stick_traffic(input int n);
    int made;
    int ticks;
    made = 0;
    while (made < n) begin
      queue_req(REQ_SAMPLE, pick_raw(nx_m), pick_raw(ny_m));
      made++;
      ticks = ($urandom_range(7) == 0) ? $urandom_range(300, 40) : $urandom_range(12);
      while (ticks > 0 && made < n) begin
        queue_req(REQ_TICK, 10'($urandom), 10'($urandom));
        ticks--;
        made++;
      end
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 0) begin
        // The neutral and reach registers keep their reset values in this phase.
        queue_reg(REG_QUAD_NE, {8'h50, 8'h60, 10'd700, 10'd700});
        queue_reg(REG_QUAD_SE, {8'h48, 8'h58, 10'd300, 10'd700});
        queue_reg(REG_QUAD_SW, {8'h40, 8'h40, 10'd300, 10'd300});
        queue_reg(REG_QUAD_NW, {8'h30, 8'h70, 10'd700, 10'd300});
        queue_reg(REG_CARDINAL, {4'h0, 8'hC0, 8'h10, 8'h80, 8'hFF});
        queue_reg(4'(RegCount + $urandom_range(7)), rand36());
        wait_cfg_done();
        queue_req(REQ_TICK, 10'd0, 10'd0);
        queue_req(REQ_SAMPLE, 10'd1023, 10'd1023);
        repeat (3) queue_req(REQ_TICK, '1, '1);
        queue_req(REQ_SAMPLE, 10'd0, 10'd0);
        queue_req(REQ_SAMPLE, 10'd512, 10'd512);
        queue_req(REQ_SAMPLE, 10'd600, 10'd400);
        queue_req(REQ_SAMPLE, 10'd1023, 10'd0);
        queue_req(REQ_SAMPLE, 10'd0, 10'd1023);
        queue_req(REQ_SAMPLE, 10'd200, 10'd900);
        queue_req(REQ_SAMPLE, 10'd513, 10'd513);
        queue_req(REQ_SAMPLE, 10'd700, 10'd700);
        queue_req(REQ_SAMPLE, 10'd701, 10'd300);
        queue_req(REQ_SAMPLE, 10'd300, 10'd299);
        repeat (8) queue_req(REQ_TICK, 10'($urandom), 10'($urandom));
        n = 150;
      end else begin
        wait_drained();
        repeat (SettleCycles) @(posedge clk_i);
        case (ph)
          2:       program_regs(CFG_LOW_EDGE);
          4:       program_regs(CFG_HIGH_EDGE);
          6:       program_regs(CFG_LIMIT_EDGE);
          default: program_regs(CFG_RANDOM);
        endcase
        n = 220;
      end

      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase

      // The sender holds off halfway until every result is back.
      gen_stick_traffic(n / 2);
      wait_drained();
      gen_stick_traffic(n - n / 2);
    end

    wait_drained();
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
